// ----- src/rau_pkg.sv -----
`default_nettype none

package rau_pkg;

    // operation codes carried in tuser
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_INC = 2'd2;
    localparam logic [1:0] OP_CMP = 2'd3;

    // result field widths, fixed by the output format
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 30;
    localparam int RES_BITS  = RES_NUM_W + RES_DEN_W + 1;
    localparam int OUT_TW    = ((RES_BITS + 7) / 8) * 8;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    // microprogram addresses
    localparam upc_t U_EMIT      = 5'd0;
    localparam upc_t U_IDLE      = 5'd1;
    localparam upc_t U_DISP_MUL  = 5'd2;
    localparam upc_t U_DISP_INC  = 5'd3;
    localparam upc_t U_DISP_CMP  = 5'd4;
    localparam upc_t U_ADD0      = 5'd5;
    localparam upc_t U_ADD1      = 5'd6;
    localparam upc_t U_ADD2      = 5'd7;
    localparam upc_t U_MUL0      = 5'd8;
    localparam upc_t U_MUL1      = 5'd9;
    localparam upc_t U_DEN       = 5'd10;
    localparam upc_t U_INC       = 5'd11;
    localparam upc_t U_CMP       = 5'd12;
    localparam upc_t U_CHECK     = 5'd13;
    localparam upc_t U_TWOS      = 5'd14;
    localparam upc_t U_SAVE      = 5'd15;
    localparam upc_t U_STEIN     = 5'd16;
    localparam upc_t U_GTEST     = 5'd17;
    localparam upc_t U_DIVN      = 5'd18;
    localparam upc_t U_DIVN_LOOP = 5'd19;
    localparam upc_t U_DIVD      = 5'd20;
    localparam upc_t U_DIVD_LOOP = 5'd21;
    localparam upc_t U_DENQ      = 5'd22;
    localparam upc_t U_KEEP      = 5'd23;

    // datapath micro-operations
    typedef enum logic [4:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_NUM_P,
        UOP_NUM_ADD,
        UOP_DEN_P,
        UOP_INC,
        UOP_CMP,
        UOP_INIT_XY,
        UOP_HALVE2,
        UOP_SAVE,
        UOP_STEIN,
        UOP_DIV_N,
        UOP_DIV_STEP,
        UOP_DIV_D,
        UOP_DEN_Q,
        UOP_KEEP,
        UOP_EMIT
    } uop_t;

    // multiplier operand pair
    typedef enum logic [2:0] {
        MS_NONE,
        MS_AN_BD,
        MS_AN_BN,
        MS_BN_AD,
        MS_AD_BD
    } msel_t;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_OP_MUL,
        C_OP_INC,
        C_OP_CMP,
        C_NO_REDUCE,
        C_BOTH_EVEN,
        C_XY_NE,
        C_X_ONE,
        C_CNT_NZ,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        msel_t msel;
        cond_t cond;
        upc_t  target;
        logic  in_ready;
    } ctrl_t;

    typedef struct packed {
        logic op_mul;
        logic op_inc;
        logic op_cmp;
        logic no_reduce;
        logic both_even;
        logic xy_ne;
        logic x_one;
        logic cnt_nz;
        logic out_full;
    } stat_t;

endpackage

`default_nettype wire

// ----- src/rau_ucode_rom.sv -----
`default_nettype none

module rau_ucode_rom import rau_pkg::*;
(
    input  upc_t  addr,
    output ctrl_t word
);

    always_comb
    begin
        case (addr)
            U_EMIT:      word = '{UOP_EMIT,     MS_NONE,  C_OUT_FULL,  U_EMIT,      1'b0};
            U_IDLE:      word = '{UOP_LOAD,     MS_NONE,  C_NO_IN,     U_IDLE,      1'b1};
            U_DISP_MUL:  word = '{UOP_NOP,      MS_NONE,  C_OP_MUL,    U_MUL0,      1'b0};
            U_DISP_INC:  word = '{UOP_NOP,      MS_NONE,  C_OP_INC,    U_INC,       1'b0};
            U_DISP_CMP:  word = '{UOP_NOP,      MS_NONE,  C_OP_CMP,    U_CMP,       1'b0};
            // add: an*bd + bn*ad over ad*bd
            U_ADD0:      word = '{UOP_NOP,      MS_AN_BD, C_NEVER,     U_IDLE,      1'b0};
            U_ADD1:      word = '{UOP_NUM_P,    MS_BN_AD, C_NEVER,     U_IDLE,      1'b0};
            U_ADD2:      word = '{UOP_NUM_ADD,  MS_AD_BD, C_ALWAYS,    U_DEN,       1'b0};
            // multiply: an*bn over ad*bd
            U_MUL0:      word = '{UOP_NOP,      MS_AN_BN, C_NEVER,     U_IDLE,      1'b0};
            U_MUL1:      word = '{UOP_NUM_P,    MS_AD_BD, C_NEVER,     U_IDLE,      1'b0};
            U_DEN:       word = '{UOP_DEN_P,    MS_NONE,  C_ALWAYS,    U_CHECK,     1'b0};
            U_INC:       word = '{UOP_INC,      MS_NONE,  C_ALWAYS,    U_CHECK,     1'b0};
            U_CMP:       word = '{UOP_CMP,      MS_NONE,  C_ALWAYS,    U_EMIT,      1'b0};
            // reduction: strip common twos, odd gcd, then two divides unless the odd gcd is one
            U_CHECK:     word = '{UOP_INIT_XY,  MS_NONE,  C_NO_REDUCE, U_EMIT,      1'b0};
            U_TWOS:      word = '{UOP_HALVE2,   MS_NONE,  C_BOTH_EVEN, U_TWOS,      1'b0};
            U_SAVE:      word = '{UOP_SAVE,     MS_NONE,  C_NEVER,     U_IDLE,      1'b0};
            U_STEIN:     word = '{UOP_STEIN,    MS_NONE,  C_XY_NE,     U_STEIN,     1'b0};
            U_GTEST:     word = '{UOP_NOP,      MS_NONE,  C_X_ONE,     U_KEEP,      1'b0};
            U_DIVN:      word = '{UOP_DIV_N,    MS_NONE,  C_NEVER,     U_IDLE,      1'b0};
            U_DIVN_LOOP: word = '{UOP_DIV_STEP, MS_NONE,  C_CNT_NZ,    U_DIVN_LOOP, 1'b0};
            U_DIVD:      word = '{UOP_DIV_D,    MS_NONE,  C_NEVER,     U_IDLE,      1'b0};
            U_DIVD_LOOP: word = '{UOP_DIV_STEP, MS_NONE,  C_CNT_NZ,    U_DIVD_LOOP, 1'b0};
            U_DENQ:      word = '{UOP_DEN_Q,    MS_NONE,  C_ALWAYS,    U_EMIT,      1'b0};
            U_KEEP:      word = '{UOP_KEEP,     MS_NONE,  C_ALWAYS,    U_EMIT,      1'b0};
            default:     word = '{UOP_NOP,      MS_NONE,  C_ALWAYS,    U_IDLE,      1'b0};
        endcase
    end

endmodule

`default_nettype wire

// ----- src/rau_sequencer.sv -----
`default_nettype none

module rau_sequencer import rau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t stat,
    output ctrl_t ctrl
);

    upc_t pc_reg;
    upc_t pc_next;
    logic take;

    rau_ucode_rom u_rom
    (
        .addr (pc_reg),
        .word (ctrl)
    );

    always_comb
    begin
        case (ctrl.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_IN:     take = !in_valid;
            C_OP_MUL:    take = stat.op_mul;
            C_OP_INC:    take = stat.op_inc;
            C_OP_CMP:    take = stat.op_cmp;
            C_NO_REDUCE: take = stat.no_reduce;
            C_BOTH_EVEN: take = stat.both_even;
            C_XY_NE:     take = stat.xy_ne;
            C_X_ONE:     take = stat.x_one;
            C_CNT_NZ:    take = stat.cnt_nz;
            C_OUT_FULL:  take = stat.out_full;
            default:     take = 1'b0;
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            pc_next = ctrl.target;
        end
        else
        begin
            pc_next = pc_reg + upc_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= U_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/rau_datapath.sv -----
`default_nettype none

module rau_datapath import rau_pkg::*;
#(
    parameter int OPERAND_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ctrl_t                          ctrl,
    input  logic                           in_valid,
    input  logic [1:0]                     in_op,
    input  logic signed [OPERAND_BITS-1:0] in_a_num,
    input  logic [OPERAND_BITS-2:0]        in_a_den,
    input  logic signed [OPERAND_BITS-1:0] in_b_num,
    input  logic [OPERAND_BITS-2:0]        in_b_den,
    input  logic                           out_ready,
    output stat_t                          stat,
    output logic                           out_valid,
    output logic [RES_NUM_W-1:0]           res_num,
    output logic [RES_DEN_W-1:0]           res_den,
    output logic                           is_equal
);

    localparam int W   = OPERAND_BITS;
    localparam int NW  = 2 * W;
    localparam int GW  = 2 * W - 1;
    localparam int CW  = $clog2(GW);
    localparam int XW  = (NW > RES_NUM_W) ? NW : RES_NUM_W;
    localparam int DXW = (GW > RES_DEN_W) ? GW : RES_DEN_W;

    // operand and working registers
    logic [1:0]             op_reg,  op_next;
    logic signed [W-1:0]    an_reg,  an_next;
    logic [W-2:0]           ad_reg,  ad_next;
    logic signed [W-1:0]    bn_reg,  bn_next;
    logic [W-2:0]           bd_reg,  bd_next;
    logic signed [NW-1:0]   p_reg,   p_next;
    logic signed [NW-1:0]   num_reg, num_next;
    logic [GW-1:0]          den_reg, den_next;
    logic                   eq_reg,  eq_next;
    logic [GW-1:0]          x_reg,   x_next;
    logic [GW-1:0]          y_reg,   y_next;
    logic [GW-1:0]          n_reg,   n_next;
    logic [GW-1:0]          d_reg,   d_next;
    logic [GW-1:0]          q_reg,   q_next;
    logic [GW-1:0]          r_reg,   r_next;
    logic [CW-1:0]          cnt_reg, cnt_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [RES_NUM_W-1:0]   res_num_reg,   res_num_next;
    logic [RES_DEN_W-1:0]   res_den_reg,   res_den_next;
    logic                   res_eq_reg,    res_eq_next;

    logic signed [W-1:0]    mul_a;
    logic signed [W-1:0]    mul_b;
    logic signed [NW-1:0]   mul_prod;
    logic                   x_gt;
    logic [GW-1:0]          big;
    logic [GW-1:0]          lit;
    logic [GW-1:0]          dif;
    logic [GW:0]            r_sh;
    logic [GW+1:0]          r_dif;
    logic                   r_ge;
    logic signed [XW-1:0]   num_ext;
    logic [DXW-1:0]         den_ext;
    logic                   out_full;

    // shared multiplier, denominators enter as non-negative values
    always_comb
    begin
        case (ctrl.msel)
            MS_AN_BD:
            begin
                mul_a = an_reg;
                mul_b = signed'({1'b0, bd_reg});
            end
            MS_AN_BN:
            begin
                mul_a = an_reg;
                mul_b = bn_reg;
            end
            MS_BN_AD:
            begin
                mul_a = bn_reg;
                mul_b = signed'({1'b0, ad_reg});
            end
            MS_AD_BD:
            begin
                mul_a = signed'({1'b0, ad_reg});
                mul_b = signed'({1'b0, bd_reg});
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bn_reg;
            end
        endcase
    end

    assign mul_prod = NW'(mul_a) * NW'(mul_b);

    // stein step: larger minus smaller
    assign x_gt = x_reg > y_reg;
    assign big  = x_gt ? x_reg : y_reg;
    assign lit  = x_gt ? y_reg : x_reg;
    assign dif  = big - lit;

    // restoring divide by the odd gcd held in x
    assign r_sh  = {r_reg, q_reg[GW-1]};
    assign r_dif = {1'b0, r_sh} - {2'b00, x_reg};
    assign r_ge  = !r_dif[GW+1];

    assign out_full = out_valid_reg && !out_ready;

    assign stat.op_mul    = (op_reg == OP_MUL);
    assign stat.op_inc    = (op_reg == OP_INC);
    assign stat.op_cmp    = (op_reg == OP_CMP);
    assign stat.no_reduce = num_reg[NW-1] || (num_reg == '0) || (den_reg == '0);
    assign stat.both_even = !x_reg[0] && !y_reg[0];
    assign stat.xy_ne     = (x_reg != y_reg);
    assign stat.x_one     = (x_reg == GW'(1));
    assign stat.cnt_nz    = (cnt_reg != '0);
    assign stat.out_full  = out_full;

    always_comb
    begin
        op_next  = op_reg;
        an_next  = an_reg;
        ad_next  = ad_reg;
        bn_next  = bn_reg;
        bd_next  = bd_reg;
        num_next = num_reg;
        den_next = den_reg;
        eq_next  = eq_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        n_next   = n_reg;
        d_next   = d_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;

        if (ctrl.msel != MS_NONE)
        begin
            p_next = mul_prod;
        end
        else
        begin
            p_next = p_reg;
        end

        case (ctrl.uop)
            UOP_LOAD:
            begin
                if (in_valid)
                begin
                    op_next = in_op;
                    an_next = in_a_num;
                    ad_next = in_a_den;
                    bn_next = in_b_num;
                    bd_next = in_b_den;
                    eq_next = 1'b0;
                end
            end
            UOP_NUM_P:
            begin
                num_next = p_reg;
            end
            UOP_NUM_ADD:
            begin
                num_next = num_reg + p_reg;
            end
            UOP_DEN_P:
            begin
                den_next = p_reg[GW-1:0];
            end
            UOP_INC:
            begin
                num_next = NW'(an_reg) + signed'(NW'(ad_reg));
                den_next = GW'(ad_reg);
            end
            UOP_CMP:
            begin
                eq_next  = (an_reg == bn_reg) && (ad_reg == bd_reg);
                num_next = '0;
                den_next = '0;
            end
            UOP_INIT_XY:
            begin
                x_next = num_reg[GW-1:0];
                y_next = den_reg;
            end
            UOP_HALVE2:
            begin
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                end
            end
            UOP_SAVE:
            begin
                n_next = x_reg;
                d_next = y_reg;
            end
            UOP_STEIN:
            begin
                if (x_reg != y_reg)
                begin
                    if (!x_reg[0])
                    begin
                        x_next = x_reg >> 1;
                    end
                    else if (!y_reg[0])
                    begin
                        y_next = y_reg >> 1;
                    end
                    else if (x_gt)
                    begin
                        x_next = dif >> 1;
                    end
                    else
                    begin
                        y_next = dif >> 1;
                    end
                end
            end
            UOP_DIV_N:
            begin
                q_next   = n_reg;
                r_next   = '0;
                cnt_next = CW'(GW - 1);
            end
            UOP_DIV_STEP:
            begin
                r_next   = r_ge ? r_dif[GW-1:0] : r_sh[GW-1:0];
                q_next   = {q_reg[GW-2:0], r_ge};
                cnt_next = cnt_reg - CW'(1);
            end
            UOP_DIV_D:
            begin
                num_next = signed'(NW'(q_reg));
                q_next   = d_reg;
                r_next   = '0;
                cnt_next = CW'(GW - 1);
            end
            UOP_DEN_Q:
            begin
                den_next = q_reg;
            end
            UOP_KEEP:
            begin
                num_next = signed'(NW'(n_reg));
                den_next = d_reg;
            end
            default:
            begin
            end
        endcase
    end

    // result formatting: numerator sign-extends, denominator zero-extends
    assign num_ext = XW'(num_reg);
    assign den_ext = DXW'(den_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        res_eq_next    = res_eq_reg;
        if ((ctrl.uop == UOP_EMIT) && !out_full)
        begin
            out_valid_next = 1'b1;
            res_num_next   = num_ext[RES_NUM_W-1:0];
            res_den_next   = den_ext[RES_DEN_W-1:0];
            res_eq_next    = eq_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        p_reg       <= p_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        eq_reg      <= eq_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        q_reg       <= q_next;
        r_reg       <= r_next;
        cnt_reg     <= cnt_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_eq_reg  <= res_eq_next;
    end

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign is_equal  = res_eq_reg;

endmodule

`default_nettype wire

// ----- src/rational_arith_unit_top.sv -----
`default_nettype none

// channel | dir | transaction carries                  | tdata / tuser layout (lsb first)
// --------+-----+--------------------------------------+---------------------------------------
// s_axis  | in  | one operation on two fractions       | tdata: a_num, a_den, b_num, b_den, pad
//         |     |                                      | tuser: op
// m_axis  | out | one result fraction or equality flag | tdata: res_num, res_den, is_equal, pad
//
// steps: compare results and unreduced results skip the reduction steps; reduced results
//   strip common factors of two and run the iterative gcd loop, then the two bit-serial
//   divides when the odd gcd is above one
// reset: rst_n puts the sequencer at its idle step and clears the output valid, the block then waits for input
// stalls: a finished result sits in the output register; the next transaction is taken while
//   it waits, and the sequencer holds at its emit step only if a second result is ready first

module rational_arith_unit_top import rau_pkg::*;
#(
    parameter int OPERAND_BITS = 16
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,

    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // a_num, a_den, b_num, b_den, zero pad
    input  logic [((4*OPERAND_BITS-2+7)/8)*8-1:0]       s_axis_tdata,
    // op
    input  logic [1:0]                                  s_axis_tuser,

    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // res_num, res_den, is_equal, zero pad
    output logic [OUT_TW-1:0]                           m_axis_tdata
);

    localparam int W = OPERAND_BITS;

    ctrl_t                ctrl;
    stat_t                stat;
    logic signed [W-1:0]  a_num;
    logic [W-2:0]         a_den;
    logic signed [W-1:0]  b_num;
    logic [W-2:0]         b_den;
    logic [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0] res_den;
    logic                 is_equal;

    // unpack the input transaction
    assign a_num = signed'(s_axis_tdata[W-1:0]);
    assign a_den = s_axis_tdata[2*W-2:W];
    assign b_num = signed'(s_axis_tdata[3*W-2:2*W-1]);
    assign b_den = s_axis_tdata[4*W-3:3*W-1];

    // only the idle step of the program takes input
    assign s_axis_tready = ctrl.in_ready;

    rau_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    rau_datapath #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_valid  (s_axis_tvalid),
        .in_op     (s_axis_tuser),
        .in_a_num  (a_num),
        .in_a_den  (a_den),
        .in_b_num  (b_num),
        .in_b_den  (b_den),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .res_num   (res_num),
        .res_den   (res_den),
        .is_equal  (is_equal)
    );

    // pack the result transaction
    assign m_axis_tdata = {{(OUT_TW-RES_BITS){1'b0}}, is_equal, res_den, res_num};

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb import rau_pkg::*;
;

    localparam int OPND_W         = 16;
    localparam int IN_TW          = ((4*OPND_W-2+7)/8)*8;
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transaction on either side
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off for the backpressure test
    localparam int DRAIN_CYCLES   = 300;

    // one result as it sits in m_axis_tdata, lsb first: res_num, res_den, is_equal
    typedef struct packed {
        logic        eq;
        logic [29:0] den;
        logic [31:0] num;
    } frac_result_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_TW-1:0]   s_axis_tdata;
    logic [1:0]         s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_TW-1:0]  m_axis_tdata;

    // results predicted at input acceptance, oldest first
    frac_result_t pending_results[$];

    int  mismatch_count;
    int  results_checked;
    int  equal_hits;
    int  op_count[4];
    bit  sender_idle_en;
    bit  receiver_idle_en;
    int  hold_request;      // set by a test, consumed by the receiver process
    int  idle_cycles;

    rational_arith_unit_top #(
        .OPERAND_BITS (OPND_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // fraction arithmetic with gcd reduction, done in 64-bit wrapping arithmetic
    function automatic frac_result_t predict_fraction(logic [1:0] op,
                                                      logic signed [15:0] an, logic [14:0] ad,
                                                      logic signed [15:0] bn, logic [14:0] bd);
        longint       num;
        longint       den;
        longint       x;
        longint       y;
        longint       t;
        longint       san;
        longint       sbn;
        longint       uad;
        longint       ubd;
        frac_result_t r;
        san = an;
        sbn = bn;
        uad = ad;
        ubd = bd;
        num = 0;
        den = 0;
        r   = '0;
        if (op == OP_CMP)
        begin
            r.eq = (an == bn) && (ad == bd);
            return r;
        end
        if (op == OP_ADD)
        begin
            num = san * ubd + sbn * uad;
            den = uad * ubd;
        end
        else if (op == OP_MUL)
        begin
            num = san * sbn;
            den = uad * ubd;
        end
        else
        begin
            num = san + uad;
            den = uad;
        end
        // only strictly positive fractions get reduced
        if (num > 0 && den != 0)
        begin
            x = num;
            y = den;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            num = num / x;
            den = den / x;
        end
        r.num = num[31:0];
        r.den = den[29:0];
        return r;
    endfunction

    task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, field, got,
                 want);
    endtask

    // input monitor: predict on every accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            op_count[s_axis_tuser]++;
            pending_results.push_back(predict_fraction(s_axis_tuser,
                                                       s_axis_tdata[15:0], s_axis_tdata[30:16],
                                                       s_axis_tdata[46:31], s_axis_tdata[61:47]));
        end
    end

    // output checker: every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        frac_result_t got;
        frac_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[62:0];
            if (pending_results.size() == 0)
                flag_mismatch("unexpected result num", got.num, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.eq)
                    equal_hits++;
                if (got.num !== want.num)
                    flag_mismatch("res_num", got.num, want.num);
                if (got.den !== want.den)
                    flag_mismatch("res_den", 32'(got.den), 32'(want.den));
                if (got.eq !== want.eq)
                    flag_mismatch("is_equal", 32'(got.eq), 32'(want.eq));
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial
    begin
        int n;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                m_axis_tready <= 1'b0;
                n = hold_request;
                hold_request = 0;
                for (int i = 1; i < n; i++)
                    @(posedge clk);
            end
            else if (receiver_idle_en && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 7);
                repeat (n - 1) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog: ends the run when no transaction moves for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL rational_arith_unit_top");
        $finish;
    end

    // offer one operation and wait until it is accepted
    task automatic send_op(logic [1:0] op, logic [15:0] an, logic [14:0] ad,
                           logic [15:0] bn, logic [14:0] bd);
        int gap;
        if (sender_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, bd, bn, ad, an};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_numerator();
        case ($urandom_range(0, 7))
            0:       return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
            1, 2, 3: return 16'($urandom_range(0, 40) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] pick_denominator();
        case ($urandom_range(0, 39))
            0:              return 15'd0;
            1:              return 15'h7fff;
            2:              return 15'd1;
            3, 4, 5, 6, 7,
            8, 9, 10, 11:   return 15'($urandom_range(1, 24));
            12, 13, 14:     return 15'(1 << $urandom_range(0, 14));
            default:        return 15'($urandom_range(1, 32767));
        endcase
    endfunction

    // one random operation; compares often get an identical or near-identical second fraction
    task automatic send_random_op();
        logic [1:0]  op;
        logic [15:0] an;
        logic [15:0] bn;
        logic [14:0] ad;
        logic [14:0] bd;
        op = 2'($urandom_range(0, 3));
        an = pick_numerator();
        ad = pick_denominator();
        bn = pick_numerator();
        bd = pick_denominator();
        if (op == OP_CMP)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    bn = an;
                    bd = ad;
                end
                1:
                begin
                    bn = an ^ 16'(1 << $urandom_range(0, 15));
                    bd = ad;
                end
                2:
                begin
                    bn = an;
                    bd = ad ^ 15'(1 << $urandom_range(0, 14));
                end
                default: ;
            endcase
        end
        send_op(op, an, ad, bn, bd);
    endtask

    // extremes of every field, each operation, zero and negative numerators, zero denominators
    task automatic test_directed();
        send_op(OP_ADD, 16'sd32767, 15'd32767, 16'sd32767, 15'd32767);
        send_op(OP_ADD, -16'sd32768, 15'd1, -16'sd32768, 15'd1);
        send_op(OP_ADD, 16'sd0, 15'd5, 16'sd0, 15'd7);
        send_op(OP_ADD, 16'sd1, 15'd6, 16'sd1, 15'd3);
        send_op(OP_ADD, 16'sd3, 15'd0, 16'sd4, 15'd5);
        send_op(OP_ADD, 16'sd1, 15'd4, -16'sd1, 15'd4);
        send_op(OP_MUL, -16'sd32768, 15'd32767, -16'sd32768, 15'd32767);
        send_op(OP_MUL, 16'sd32767, 15'd1, -16'sd32768, 15'd1);
        send_op(OP_MUL, 16'sd16384, 15'd16384, 16'sd16384, 15'd16384);
        send_op(OP_MUL, 16'sd6, 15'd4, 16'sd10, 15'd6);
        send_op(OP_MUL, 16'sd2, 15'd7, 16'sd3, 15'd0);
        send_op(OP_MUL, 16'sd0, 15'd0, 16'sd0, 15'd0);
        send_op(OP_MUL, 16'sd30030, 15'd30030, 16'sd255, 15'd4095);
        send_op(OP_INC, 16'sd5, 15'd10, 16'h5a5a, 15'h2a5a);
        send_op(OP_INC, -16'sd5, 15'd3, 16'sd0, 15'd0);
        send_op(OP_INC, -16'sd3, 15'd3, 16'sd1, 15'd1);
        send_op(OP_INC, 16'sd32767, 15'd32767, -16'sd32768, 15'd32767);
        send_op(OP_INC, 16'sd9, 15'd0, 16'sd9, 15'd0);
        send_op(OP_CMP, 16'sd7, 15'd9, 16'sd7, 15'd9);
        send_op(OP_CMP, 16'sd7, 15'd9, 16'sd8, 15'd9);
        send_op(OP_CMP, 16'sd7, 15'd9, 16'sd7, 15'd10);
        send_op(OP_CMP, -16'sd32768, 15'd32767, -16'sd32768, 15'd32767);
        send_op(OP_CMP, 16'sd0, 15'd0, 16'sd0, 15'd0);
        send_op(OP_CMP, 16'sd2, 15'd4, 16'sd1, 15'd2);
    endtask

    // random operations, idling in stretches with calm windows in between
    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            sender_idle_en   = ((i / 48) % 4) != 3;
            receiver_idle_en = ((i / 40) % 3) != 2;
            send_random_op();
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure(int count);
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        hold_request     = HOLD_CYCLES;
        for (int i = 0; i < count; i++)
            send_random_op();
    endtask

    // last part of the run: both sides flat out
    task automatic test_no_idle(int count);
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        for (int i = 0; i < count; i++)
            send_random_op();
    endtask

    initial
    begin
        mismatch_count   = 0;
        results_checked  = 0;
        equal_hits       = 0;
        op_count         = '{default: 0};
        sender_idle_en   = 1'b1;
        receiver_idle_en = 1'b1;
        hold_request     = 0;
        s_axis_tvalid    <= 1'b0;
        s_axis_tdata     <= '0;
        s_axis_tuser     <= OP_ADD;
        rst_n            <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(580);
        test_backpressure(40);
        test_no_idle(60);
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d add, %0d multiply, %0d increment, %0d compare transactions",
                 op_count[OP_ADD], op_count[OP_MUL], op_count[OP_INC], op_count[OP_CMP]);
        $display("checked %0d results (%0d equal), %0d mismatches, incl. a %0d-cycle hold-off",
                 results_checked, equal_hits, mismatch_count, HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("PASS rational_arith_unit_top");
        else
            $display("FAIL rational_arith_unit_top");
        $finish;
    end

endmodule
